>>> hw/rtl/pvrs_pkg.sv
`default_nettype none
package pvrs_pkg;

  localparam int unsigned KIND_W     = 3;
  localparam int unsigned IDX_W      = 6;
  localparam int unsigned ROW_W      = 64;
  localparam int unsigned WIN_W      = 16;
  localparam int unsigned DEG_W      = 6;
  localparam int unsigned RIDX_W     = 4;
  localparam int unsigned CNT_W      = 7;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 7;
  localparam int unsigned VCNT_W     = 7;
  localparam int unsigned CCNT_W     = 5;
  localparam int unsigned CRIT_W     = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_ADJ    = 3'd0,
    KIND_VERTEX = 3'd1,
    KIND_CLASS  = 3'd2,
    KIND_POOL   = 3'd3,
    KIND_RUN    = 3'd4
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VCOUNT    = 2'd0,
    CFG_CCOUNT    = 2'd1,
    CFG_CRITERION = 2'd2
  } cfg_idx_e;

  typedef enum logic [CRIT_W-1:0] {
    CRIT_WEIGHT = 2'd0,
    CRIT_DEGREE = 2'd1,
    CRIT_NONE   = 2'd2
  } crit_e;

  localparam logic ROW_CLASS = 1'b0;
  localparam logic ROW_POOL  = 1'b1;

  localparam logic [VCNT_W-1:0] VCOUNT_RESET = 7'd64;
  localparam logic [CCNT_W-1:0] CCOUNT_RESET = 5'd16;

  // Control of the shared accumulate/compare unit.
  typedef struct packed {
    logic clr;
    logic add;
  } acc_ctl_t;

endpackage
`default_nettype wire

>>> hw/rtl/pool_vertex_reinsertion_search_core.sv
`default_nettype none
// Pool vertex reinsertion search core.
// Input channel (in_valid_i / in_stall_o): load transactions write an adjacency
// row, a vertex weight and degree, a color class row or the pool row, one per
// cycle while the core is idle. A run transaction starts the search; the core
// raises in_stall_o until the last result row has been placed in the output
// register.
// Output channel (out_valid_o / out_stall_i): a run returns one class row per
// configured color in ascending color order, then the pool row with last_o
// set. Every row carries the popcount of the final pool.
// Config port (cfg_valid_i / cfg_ready_o): always ready; write only while idle.
// A run walks the vertices; for each pooled vertex it tries the colors, and
// for a conflicting color under the weight or degree criterion it reads the
// weight memory once per conflicting neighbor through the shared accumulator.
// It then counts the pool over all MAX_VERTICES entries and emits the rows.
// Reset clears the sequencer and the pool and sets the config registers to
// their defaults; the graph and class memories hold garbage until loaded.
// A stalled receiver holds the output register; the core waits with the next
// row until the register frees up.
module pool_vertex_reinsertion_search_core
  import pvrs_pkg::*;
#(
  parameter int unsigned MAX_VERTICES = 64,
  parameter int unsigned MAX_COLORS   = 16,
  parameter int unsigned WEIGHT_BITS  = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [KIND_W-1:0]     kind_i,
  input  wire logic [IDX_W-1:0]      item_index_i,
  input  wire logic [ROW_W-1:0]      row_bits_i,
  input  wire logic [WIN_W-1:0]      vertex_weight_i,
  input  wire logic [DEG_W-1:0]      vertex_degree_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic                       row_kind_o,
  output logic [RIDX_W-1:0]          row_index_o,
  output logic [ROW_W-1:0]           result_bits_o,
  output logic [CNT_W-1:0]           pool_remaining_o,
  output logic                       last_o,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned NV    = MAX_VERTICES;
  localparam int unsigned VIW   = $clog2(NV);
  localparam int unsigned NVC_W = $clog2(NV + 1);
  localparam int unsigned CIW   = (MAX_COLORS > 1) ? $clog2(MAX_COLORS) : 1;
  localparam int unsigned NCC_W = $clog2(MAX_COLORS + 1);
  localparam int unsigned SW    = WEIGHT_BITS + 7;

  typedef enum logic [11:0] {
    S_IDLE  = 12'b0000_0000_0001,
    S_VTX   = 12'b0000_0000_0010,
    S_VLD   = 12'b0000_0000_0100,
    S_COL   = 12'b0000_0000_1000,
    S_CLD   = 12'b0000_0001_0000,
    S_SUMA  = 12'b0000_0010_0000,
    S_SUMB  = 12'b0000_0100_0000,
    S_DEC   = 12'b0000_1000_0000,
    S_CNT   = 12'b0001_0000_0000,
    S_ERD   = 12'b0010_0000_0000,
    S_EWR   = 12'b0100_0000_0000,
    S_EPOOL = 12'b1000_0000_0000
  } state_e;

  state_e state_q, state_d;

  // Config registers
  logic [VCNT_W-1:0] vcount_q;
  logic [CCNT_W-1:0] ccount_q;
  logic [CRIT_W-1:0] crit_q;

  // Search registers
  logic [NV-1:0]    pool_q, pool_d;
  logic [NVC_W-1:0] i_q, i_d;
  logic [NVC_W-1:0] k_q, k_d;
  logic [NCC_W-1:0] j_q, j_d;
  logic [NV-1:0]    adj_q, adj_d;
  logic [NV-1:0]    cls_row_q, cls_row_d;
  logic [NV-1:0]    conf_q, conf_d;
  logic [SW-1:0]    own_q, own_d;

  // Output register
  logic              out_valid_q;
  logic              row_kind_q;
  logic [RIDX_W-1:0] row_index_q;
  logic [NV-1:0]     result_q;
  logic [CNT_W-1:0]  remaining_q;
  logic              last_q;
  logic              out_load;
  logic              out_load_pool;

  // Memory ports
  logic              adj_we, vtx_we, cls_we;
  logic [NV-1:0]     adj_rd, cls_rd, cls_wdata;
  logic [WEIGHT_BITS-1:0] wt_rd;
  logic [DEG_W-1:0]  deg_rd;
  logic [VIW-1:0]    wt_raddr;
  logic [CIW-1:0]    cls_waddr;

  // Shared accumulator
  acc_ctl_t          acc_ctl;
  logic [SW-1:0]     acc_addend, acc_sum;
  logic              acc_lt;

  logic [NVC_W-1:0]  nv_sat;
  logic [NCC_W-1:0]  nc_sat;
  logic [NV-1:0]     vmask, self_bit, joined, evict, conf_now;
  logic              in_fire, out_free;
  logic [VIW-1:0]    i_idx, k_idx;

  assign in_fire    = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign cfg_ready_o = 1'b1;

  // Saturate the counts to what the storage holds.
  assign nv_sat = (32'(vcount_q) > NV) ? NVC_W'(NV) : NVC_W'(vcount_q);
  assign nc_sat = (32'(ccount_q) > MAX_COLORS) ? NCC_W'(MAX_COLORS) : NCC_W'(ccount_q);

  always_comb begin
    for (int b = 0; b < NV; b++) begin
      vmask[b] = (NVC_W'(b) < nv_sat);
    end
  end

  assign i_idx    = i_q[VIW-1:0];
  assign k_idx    = k_q[VIW-1:0];
  assign self_bit = NV'(1) << i_idx;
  assign joined   = cls_row_q | self_bit;
  assign evict    = adj_q & joined & vmask;
  assign conf_now = adj_q & cls_rd & vmask;
  assign wt_raddr = (state_q == S_SUMA) ? k_idx : i_idx;

  // Load writes
  assign adj_we = in_fire && (kind_i == KIND_ADJ) && (32'(item_index_i) < NV);
  assign vtx_we = in_fire && (kind_i == KIND_VERTEX) && (32'(item_index_i) < NV);

  pvrs_graph_mem #(
    .NV   (NV),
    .NCOL (MAX_COLORS),
    .WB   (WEIGHT_BITS)
  ) u_mem (
    .clk_i       (clk_i),
    .adj_we_i    (adj_we),
    .vtx_we_i    (vtx_we),
    .vtx_waddr_i (item_index_i[VIW-1:0]),
    .adj_wdata_i (row_bits_i[NV-1:0]),
    .wt_wdata_i  (WEIGHT_BITS'(vertex_weight_i)),
    .deg_wdata_i (vertex_degree_i),
    .adj_raddr_i (i_idx),
    .wt_raddr_i  (wt_raddr),
    .adj_rdata_o (adj_rd),
    .wt_rdata_o  (wt_rd),
    .deg_rdata_o (deg_rd),
    .cls_we_i    (cls_we),
    .cls_waddr_i (cls_waddr),
    .cls_wdata_i (cls_wdata),
    .cls_raddr_i (j_q[CIW-1:0]),
    .cls_rdata_o (cls_rd)
  );

  pvrs_accum #(
    .SW (SW)
  ) u_acc (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (acc_ctl),
    .addend_i (acc_addend),
    .own_i    (own_q),
    .sum_o    (acc_sum),
    .lt_o     (acc_lt)
  );

  // Sequencer
  always_comb begin
    state_d       = state_q;
    pool_d        = pool_q;
    i_d           = i_q;
    k_d           = k_q;
    j_d           = j_q;
    adj_d         = adj_q;
    cls_row_d     = cls_row_q;
    conf_d        = conf_q;
    own_d         = own_q;
    cls_we        = 1'b0;
    cls_waddr     = j_q[CIW-1:0];
    cls_wdata     = row_bits_i[NV-1:0];
    acc_ctl       = '0;
    acc_addend    = (crit_q == CRIT_WEIGHT) ? SW'(wt_rd) : SW'(deg_rd);
    out_load      = 1'b0;
    out_load_pool = 1'b0;

    case (state_q)
      S_IDLE: begin
        cls_waddr = item_index_i[CIW-1:0];
        if (in_fire) begin
          case (kind_i)
            KIND_CLASS: cls_we = (32'(item_index_i) < MAX_COLORS);
            KIND_POOL:  pool_d = row_bits_i[NV-1:0];
            KIND_RUN: begin
              // Drop pool bits of vertices not in use.
              pool_d  = pool_q & vmask;
              i_d     = '0;
              state_d = S_VTX;
            end
            default: ;
          endcase
        end
      end
      S_VTX: begin
        if (i_q == nv_sat || pool_q == '0) begin
          acc_ctl.clr = 1'b1;
          k_d         = '0;
          state_d     = S_CNT;
        end else if (!pool_q[i_idx]) begin
          i_d = i_q + 1'b1;
        end else begin
          state_d = S_VLD;
        end
      end
      S_VLD: begin
        adj_d   = adj_rd;
        own_d   = (crit_q == CRIT_WEIGHT) ? SW'(wt_rd) : SW'(deg_rd);
        j_d     = '0;
        state_d = S_COL;
      end
      S_COL: begin
        if (j_q == nc_sat || !pool_q[i_idx]) begin
          i_d     = i_q + 1'b1;
          state_d = S_VTX;
        end else begin
          state_d = S_CLD;
        end
      end
      S_CLD: begin
        if (conf_now == '0) begin
          // Place without conflict.
          cls_we    = 1'b1;
          cls_wdata = cls_rd | self_bit;
          pool_d    = pool_q & ~self_bit;
          j_d       = j_q + 1'b1;
          state_d   = S_COL;
        end else if (crit_q != CRIT_WEIGHT && crit_q != CRIT_DEGREE) begin
          j_d     = j_q + 1'b1;
          state_d = S_COL;
        end else begin
          conf_d      = conf_now;
          cls_row_d   = cls_rd;
          acc_ctl.clr = 1'b1;
          k_d         = '0;
          state_d     = S_SUMA;
        end
      end
      S_SUMA: begin
        if (k_q == nv_sat) begin
          state_d = S_DEC;
        end else if (conf_q[k_idx]) begin
          state_d = S_SUMB;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      S_SUMB: begin
        acc_ctl.add = 1'b1;
        k_d         = k_q + 1'b1;
        state_d     = S_SUMA;
      end
      S_DEC: begin
        if (acc_lt) begin
          // Place and send the conflicting neighbors back to the pool.
          cls_we    = 1'b1;
          cls_wdata = joined & ~evict;
          pool_d    = (pool_q & ~self_bit) | evict;
        end
        j_d     = j_q + 1'b1;
        state_d = S_COL;
      end
      S_CNT: begin
        acc_ctl.add = 1'b1;
        acc_addend  = SW'(pool_q[k_idx]);
        if (k_q == NVC_W'(NV - 1)) begin
          j_d     = '0;
          state_d = S_ERD;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      S_ERD: begin
        state_d = (j_q == nc_sat) ? S_EPOOL : S_EWR;
      end
      S_EWR: begin
        if (out_free) begin
          out_load = 1'b1;
          j_d      = j_q + 1'b1;
          state_d  = S_ERD;
        end
      end
      S_EPOOL: begin
        if (out_free) begin
          out_load      = 1'b1;
          out_load_pool = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      pool_q   <= '0;
      i_q      <= '0;
      k_q      <= '0;
      j_q      <= '0;
      vcount_q <= VCOUNT_RESET;
      ccount_q <= CCOUNT_RESET;
      crit_q   <= CRIT_WEIGHT;
    end else begin
      state_q <= state_d;
      pool_q  <= pool_d;
      i_q     <= i_d;
      k_q     <= k_d;
      j_q     <= j_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_VCOUNT:    vcount_q <= cfg_data_i[VCNT_W-1:0];
          CFG_CCOUNT:    ccount_q <= cfg_data_i[CCNT_W-1:0];
          CFG_CRITERION: crit_q   <= cfg_data_i[CRIT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    adj_q     <= adj_d;
    cls_row_q <= cls_row_d;
    conf_q    <= conf_d;
    own_q     <= own_d;
  end

  // Output register: hold while stalled, advance when taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      row_kind_q  <= out_load_pool ? ROW_POOL : ROW_CLASS;
      row_index_q <= out_load_pool ? '0 : RIDX_W'(j_q);
      result_q    <= out_load_pool ? (pool_q & vmask) : (cls_rd & vmask);
      remaining_q <= CNT_W'(acc_sum);
      last_q      <= out_load_pool;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign row_kind_o       = row_kind_q;
  assign row_index_o      = row_index_q;
  assign result_bits_o    = ROW_W'(result_q);
  assign pool_remaining_o = remaining_q;
  assign last_o           = last_q;

  a_run_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && kind_i == KIND_RUN) |=> (state_q == S_VTX))
    else $error("run did not start the vertex walk");

  a_dec_has_conflict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DEC) |-> (conf_q != '0))
    else $error("criterion check without conflicts");

  a_pool_masked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> ((pool_q & ~vmask) == '0))
    else $error("pool holds vertices not in use during a run");

  a_color_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_COL || state_q == S_ERD) |-> (j_q <= nc_sat))
    else $error("color counter past color count");

  a_last_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load_pool |=> (state_q == S_IDLE && out_valid_q && last_q))
    else $error("pool row not final");

endmodule
`default_nettype wire

>>> hw/rtl/pvrs_graph_mem.sv
`default_nettype none
module pvrs_graph_mem
  import pvrs_pkg::*;
#(
  parameter int unsigned NV   = 64,
  parameter int unsigned NCOL = 16,
  parameter int unsigned WB   = 16
) (
  input  wire logic                   clk_i,
  input  wire logic                   adj_we_i,
  input  wire logic                   vtx_we_i,
  input  wire logic [$clog2(NV)-1:0]  vtx_waddr_i,
  input  wire logic [NV-1:0]          adj_wdata_i,
  input  wire logic [WB-1:0]          wt_wdata_i,
  input  wire logic [DEG_W-1:0]       deg_wdata_i,
  input  wire logic [$clog2(NV)-1:0]  adj_raddr_i,
  input  wire logic [$clog2(NV)-1:0]  wt_raddr_i,
  output logic      [NV-1:0]          adj_rdata_o,
  output logic      [WB-1:0]          wt_rdata_o,
  output logic      [DEG_W-1:0]       deg_rdata_o,
  input  wire logic                   cls_we_i,
  input  wire logic [((NCOL > 1) ? $clog2(NCOL) : 1)-1:0] cls_waddr_i,
  input  wire logic [NV-1:0]          cls_wdata_i,
  input  wire logic [((NCOL > 1) ? $clog2(NCOL) : 1)-1:0] cls_raddr_i,
  output logic      [NV-1:0]          cls_rdata_o
);

  logic [NV-1:0]    adj_mem [NV];
  logic [WB-1:0]    wt_mem  [NV];
  logic [DEG_W-1:0] deg_mem [NV];
  logic [NV-1:0]    cls_mem [NCOL];

  always_ff @(posedge clk_i) begin
    if (adj_we_i) begin
      adj_mem[vtx_waddr_i] <= adj_wdata_i;
    end
    adj_rdata_o <= adj_mem[adj_raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (vtx_we_i) begin
      wt_mem[vtx_waddr_i]  <= wt_wdata_i;
      deg_mem[vtx_waddr_i] <= deg_wdata_i;
    end
    wt_rdata_o  <= wt_mem[wt_raddr_i];
    deg_rdata_o <= deg_mem[wt_raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (cls_we_i) begin
      cls_mem[cls_waddr_i] <= cls_wdata_i;
    end
    cls_rdata_o <= cls_mem[cls_raddr_i];
  end

endmodule
`default_nettype wire

>>> hw/rtl/pvrs_accum.sv
`default_nettype none
module pvrs_accum
  import pvrs_pkg::*;
#(
  parameter int unsigned SW = 23
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire acc_ctl_t      ctl_i,
  input  wire logic [SW-1:0] addend_i,
  input  wire logic [SW-1:0] own_i,
  output logic      [SW-1:0] sum_o,
  output logic               lt_o
);

  logic [SW-1:0] sum_q, sum_d;

  always_comb begin
    sum_d = sum_q;
    if (ctl_i.clr) begin
      sum_d = '0;
    end else if (ctl_i.add) begin
      sum_d = sum_q + addend_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else begin
      sum_q <= sum_d;
    end
  end

  assign sum_o = sum_q;
  assign lt_o  = (sum_q < own_i);

endmodule
`default_nettype wire
